// File: sv/fdts_pkg.sv
`default_nettype none
package fdts_pkg;

   // Counter width default and register port widths
   localparam int CNT_W_DEF = 16;
   localparam int REG_W     = 16;
   localparam int CMD_W     = 16;
   localparam int STAT_W    = 3;
   localparam int CSR_IDX_W = 3;

   // Register indexes
   localparam logic [CSR_IDX_W-1:0] CSR_LED_PHASE = 3'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_HEARTBEAT = 3'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_INIT      = 3'd2;
   localparam logic [CSR_IDX_W-1:0] CSR_BLINK     = 3'd3;
   localparam logic [CSR_IDX_W-1:0] CSR_START     = 3'd4;

   // Register reset values
   localparam logic [REG_W-1:0] LED_PHASE_RST = 16'd300;
   localparam logic [REG_W-1:0] HEARTBEAT_RST = 16'd200;
   localparam logic [REG_W-1:0] INIT_RST      = 16'd1000;
   localparam logic [REG_W-1:0] BLINK_RST     = 16'd1000;
   localparam logic [REG_W-1:0] START_RST     = 16'h000F;

   typedef struct packed {
      logic             left_low;
      logic             left_full;
      logic             right_low;
      logic             right_full;
      logic [CMD_W-1:0] host_command;
   } req_type;

   typedef struct packed {
      logic [REG_W-1:0] led_phase_ticks;
      logic [REG_W-1:0] heartbeat_ticks;
      logic [REG_W-1:0] init_ticks;
      logic [REG_W-1:0] blink_ticks;
      logic [REG_W-1:0] start_code;
   } cfg_type;

   typedef struct packed {
      logic              led_red;
      logic              led_green;
      logic              led_yellow;
      logic              left_light;
      logic              right_light;
      logic              valve_open;
      logic [STAT_W-1:0] status_code;
      logic              left_empty_flag;
      logic              left_full_flag;
      logic              right_empty_flag;
      logic              right_full_flag;
      logic [CMD_W-1:0]  command_echo;
   } rsp_type;

endpackage
`default_nettype wire

// File: sv/fdts_req_if.sv
`default_nettype none
interface fdts_req_if;
   import fdts_pkg::*;

   logic             valid;
   logic             ready;
   logic             left_low;
   logic             left_full;
   logic             right_low;
   logic             right_full;
   logic [CMD_W-1:0] host_command;

   modport source (output valid, left_low, left_full, right_low, right_full, host_command,
                   input ready);
   modport sink   (input valid, left_low, left_full, right_low, right_full, host_command,
                   output ready);
endinterface
`default_nettype wire

// File: sv/fdts_rsp_if.sv
`default_nettype none
interface fdts_rsp_if;
   import fdts_pkg::*;

   logic              valid;
   logic              ready;
   logic              led_red;
   logic              led_green;
   logic              led_yellow;
   logic              left_light;
   logic              right_light;
   logic              valve_open;
   logic [STAT_W-1:0] status_code;
   logic              left_empty_flag;
   logic              left_full_flag;
   logic              right_empty_flag;
   logic              right_full_flag;
   logic [CMD_W-1:0]  command_echo;

   modport source (output valid, led_red, led_green, led_yellow, left_light, right_light,
                   valve_open, status_code, left_empty_flag, left_full_flag,
                   right_empty_flag, right_full_flag, command_echo,
                   input ready);
   modport sink   (input valid, led_red, led_green, led_yellow, left_light, right_light,
                   valve_open, status_code, left_empty_flag, left_full_flag,
                   right_empty_flag, right_full_flag, command_echo,
                   output ready);
endinterface
`default_nettype wire

// File: sv/fdts_csr_if.sv
`default_nettype none
interface fdts_csr_if;
   import fdts_pkg::*;

   logic                 valid;
   logic                 ready;
   logic [CSR_IDX_W-1:0] index;
   logic [REG_W-1:0]     data;

   modport source (output valid, index, data, input ready);
   modport sink   (input valid, index, data, output ready);
endinterface
`default_nettype wire

// File: sv/fdts_core.sv
`default_nettype none
module fdts_core #(
   parameter int COUNT_WIDTH = fdts_pkg::CNT_W_DEF
) (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic              step,
   input  wire fdts_pkg::req_type req,
   input  wire fdts_pkg::cfg_type cfg,
   output fdts_pkg::rsp_type      rsp
);
   import fdts_pkg::*;

   localparam int CW    = COUNT_WIDTH;
   localparam int CMP_W = (CW > REG_W) ? CW : REG_W;
   localparam logic [CW-1:0]    CNT_ALL1 = {CW{1'b1}};
   localparam logic [CMP_W-1:0] CNT_MAX  = CMP_W'(CNT_ALL1);
   localparam logic [CMP_W-1:0] ONE_C    = CMP_W'(1);

   // Mode codes
   localparam logic [2:0] M_INIT    = 3'd0;
   localparam logic [2:0] M_WAIT    = 3'd1;
   localparam logic [2:0] M_FILL    = 3'd2;
   localparam logic [2:0] M_BOTH    = 3'd3;
   localparam logic [2:0] M_DRAIN   = 3'd4;
   localparam logic [2:0] M_DRAINED = 3'd5;

   // LED phase codes
   localparam logic [2:0] PH_RED    = 3'd4;
   localparam logic [2:0] PH_GREEN  = 3'd3;
   localparam logic [2:0] PH_YELLOW = 3'd2;
   localparam logic [2:0] PH_DONE   = 3'd0;

   // Status codes
   localparam logic [STAT_W-1:0] ST_POWER   = 3'd0;
   localparam logic [STAT_W-1:0] ST_INIT    = 3'd1;
   localparam logic [STAT_W-1:0] ST_WAIT    = 3'd2;
   localparam logic [STAT_W-1:0] ST_FILL    = 3'd3;
   localparam logic [STAT_W-1:0] ST_BOTH    = 3'd4;
   localparam logic [STAT_W-1:0] ST_DRAIN   = 3'd5;
   localparam logic [STAT_W-1:0] ST_DRAINED = 3'd6;

   typedef struct packed {
      logic valve;
      logic right;
      logic left;
      logic yellow;
      logic green;
      logic red;
   } drive_type;

   typedef struct packed {
      logic rfull;
      logic rempty;
      logic lfull;
      logic lempty;
   } flags_type;

   function automatic logic [CW-1:0] bump(input logic [CW-1:0] c);
      return (c == CNT_ALL1) ? c : c + 1'b1;
   endfunction

   function automatic logic [CMP_W-1:0] clamp_period(input logic [REG_W-1:0] v);
      logic [CMP_W-1:0] w;
      w = CMP_W'(v);
      if (w == '0) return ONE_C;
      return (w > CNT_MAX) ? CNT_MAX : w;
   endfunction

   logic [2:0]        phase_ff, phase_in;
   logic [CW-1:0]     led_cnt_ff, led_cnt_in;
   logic [CW-1:0]     blink_cnt_ff, blink_cnt_in;
   logic [CW-1:0]     init_cnt_ff, init_cnt_in;
   logic [2:0]        mode_ff, mode_in;
   drive_type         drive_ff, drive_in;
   logic [STAT_W-1:0] status_ff, status_in;
   flags_type         flags_ff, flags_in;
   logic [CMD_W-1:0]  cmd_ff, cmd_in;
   logic              first_ff, first_in;

   logic [CMP_W-1:0]  led_lim;
   logic [CMP_W-1:0]  beat_per;
   logic [CW-1:0]     led_bumped;
   logic [CW-1:0]     init_bumped;
   logic [CW-1:0]     blink_bumped;
   logic              all_dry;

   assign led_lim  = (CMP_W'(cfg.led_phase_ticks) > CNT_MAX) ? CNT_MAX
                                                             : CMP_W'(cfg.led_phase_ticks);
   assign beat_per = clamp_period(first_ff ? cfg.led_phase_ticks : cfg.heartbeat_ticks);
   assign led_bumped   = bump(led_cnt_ff);
   assign init_bumped  = bump(init_cnt_ff);
   assign blink_bumped = bump(blink_cnt_ff);
   assign all_dry = !(req.left_low | req.left_full | req.right_low | req.right_full);

   // Next state for one tick
   always_comb begin
      phase_in     = phase_ff;
      led_cnt_in   = led_cnt_ff;
      blink_cnt_in = blink_cnt_ff;
      init_cnt_in  = init_cnt_ff;
      mode_in      = mode_ff;
      drive_in     = drive_ff;
      status_in    = status_ff;
      flags_in     = flags_ff;
      cmd_in       = cmd_ff;
      first_in     = first_ff;

      // power-on LED sequence, then heartbeat
      if (phase_ff != PH_DONE) begin
         if (CMP_W'(led_cnt_ff) < led_lim) begin
            led_cnt_in = led_bumped;
            unique case (phase_ff)
               PH_RED:    drive_in.red    = 1'b1;
               PH_GREEN:  drive_in.green  = 1'b1;
               PH_YELLOW: drive_in.yellow = 1'b1;
               default: begin
                  drive_in.yellow = 1'b0;
                  drive_in.red    = 1'b0;
               end
            endcase
         end else begin
            led_cnt_in = '0;
            phase_in   = phase_ff - 3'd1;
         end
      end else begin
         led_cnt_in = led_bumped;
         if (CMP_W'(led_bumped) >= beat_per) begin
            drive_in.green = !drive_ff.green;
            led_cnt_in     = '0;
            first_in       = 1'b0;
            flags_in       = '{rfull: req.right_full, rempty: req.right_low,
                               lfull: req.left_full, lempty: req.left_low};
         end
      end

      // mode machine, once the LED sequence has ended
      if (phase_in == PH_DONE) begin
         unique case (mode_ff)
            M_INIT: begin
               drive_in.left  = 1'b1;
               drive_in.right = 1'b1;
               drive_in.valve = 1'b1;
               init_cnt_in    = init_bumped;
               if (CMP_W'(init_bumped) >= clamp_period(cfg.init_ticks)) begin
                  drive_in.left  = 1'b0;
                  drive_in.right = 1'b0;
                  drive_in.valve = 1'b0;
                  status_in      = ST_INIT;
                  mode_in        = M_WAIT;
               end
            end
            M_WAIT: begin
               status_in    = ST_WAIT;
               blink_cnt_in = blink_bumped;
               if (CMP_W'(blink_bumped) >= clamp_period(cfg.blink_ticks)) begin
                  drive_in.left  = !drive_in.left;
                  drive_in.right = !drive_in.right;
                  blink_cnt_in   = '0;
               end
               cmd_in = req.host_command;
               if (req.host_command == cfg.start_code && all_dry) begin
                  drive_in.left  = 1'b0;
                  drive_in.right = 1'b0;
                  drive_in.valve = 1'b0;
                  mode_in        = M_FILL;
               end
            end
            M_FILL: begin
               status_in = ST_FILL;
               if (req.left_full) begin
                  drive_in.left  = 1'b1;
                  flags_in.lfull = 1'b1;
               end
               if (req.right_full) begin
                  drive_in.right = 1'b1;
                  flags_in.rfull = 1'b1;
               end
               if (req.left_full && req.right_full) mode_in = M_BOTH;
            end
            M_BOTH: begin
               drive_in.valve = 1'b1;
               status_in      = ST_BOTH;
               mode_in        = M_DRAIN;
            end
            M_DRAIN: begin
               status_in = ST_DRAIN;
               if (all_dry) begin
                  flags_in.lfull = 1'b0;
                  flags_in.rfull = 1'b0;
                  mode_in        = M_DRAINED;
               end
            end
            default: begin
               drive_in.left   = 1'b0;
               drive_in.right  = 1'b0;
               drive_in.valve  = 1'b0;
               flags_in.lempty = 1'b1;
               flags_in.rempty = 1'b1;
               status_in       = ST_DRAINED;
               mode_in         = M_WAIT;
            end
         endcase
      end
   end

   // Advance state on each tick
   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff     <= PH_RED;
         led_cnt_ff   <= '0;
         blink_cnt_ff <= '0;
         init_cnt_ff  <= '0;
         mode_ff      <= M_INIT;
         drive_ff     <= '{red: 1'b1, default: 1'b0};
         status_ff    <= ST_POWER;
         flags_ff     <= '0;
         cmd_ff       <= '0;
         first_ff     <= 1'b1;
      end else if (step) begin
         phase_ff     <= phase_in;
         led_cnt_ff   <= led_cnt_in;
         blink_cnt_ff <= blink_cnt_in;
         init_cnt_ff  <= init_cnt_in;
         mode_ff      <= mode_in;
         drive_ff     <= drive_in;
         status_ff    <= status_in;
         flags_ff     <= flags_in;
         cmd_ff       <= cmd_in;
         first_ff     <= first_in;
      end
   end

   // Result of this tick
   always_comb begin
      rsp.led_red          = drive_in.red;
      rsp.led_green        = drive_in.green;
      rsp.led_yellow       = drive_in.yellow;
      rsp.left_light       = drive_in.left;
      rsp.right_light      = drive_in.right;
      rsp.valve_open       = drive_in.valve;
      rsp.status_code      = status_in;
      rsp.left_empty_flag  = flags_in.lempty;
      rsp.left_full_flag   = flags_in.lfull;
      rsp.right_empty_flag = flags_in.rempty;
      rsp.right_full_flag  = flags_in.rfull;
      rsp.command_echo     = cmd_in;
   end

   // Mode machine stays parked until the LED sequence is over
   a_mode_parked: assert property (@(posedge clock) disable iff (reset)
      phase_ff != PH_DONE |-> mode_ff == M_INIT && status_ff == ST_POWER)
      else $error("mode machine moved during power-on sequence");

   // Once done, the LED sequence never restarts
   a_phase_done_sticky: assert property (@(posedge clock) disable iff (reset)
      phase_ff == PH_DONE |=> phase_ff == PH_DONE)
      else $error("LED sequence restarted");

   // First heartbeat marker only clears after the sequence ends
   a_first_beat: assert property (@(posedge clock) disable iff (reset)
      phase_ff != PH_DONE |-> first_ff)
      else $error("heartbeat fired during power-on sequence");

endmodule
`default_nettype wire

// File: sv/fill_drain_target_sequencer_top.sv
// Fill/drain target sequencer.
// req_chan carries one timer tick per request: four level-sensor bits and the
// host command word. rsp_chan returns exactly one result per request: LED,
// light and valve drives, status code, reported level flags and command echo.
// csr_chan writes the five period/start registers by index; it is always ready
// and writes should land while no request is in flight.
// Path: a request is captured in an input register, then the core advances and
// its result lands in the output register, where it is offered until taken; a
// stall on rsp_chan holds it there. Throughput: one request per cycle while the
// receiver takes results; the input and output registers each hold one request,
// and the state update between them is combinational counter compares and a
// small mode machine.
// When the receiver stalls, the output register holds its result and the input
// register takes one more request before req_chan.ready drops.
// Reset (synchronous, active high) restores register defaults and starts the
// power-on LED sequence with red lit and all counters at zero.
`default_nettype none
module fill_drain_target_sequencer_top #(
   parameter int COUNT_WIDTH = fdts_pkg::CNT_W_DEF
) (
   input wire logic clock,
   input wire logic reset,
   fdts_req_if.sink   req_chan,
   fdts_rsp_if.source rsp_chan,
   fdts_csr_if.sink   csr_chan
);
   import fdts_pkg::*;

   cfg_type cfg_ff;
   logic    in_valid_ff;
   req_type in_data_ff;
   logic    out_valid_ff;
   rsp_type out_data_ff;
   rsp_type core_rsp;
   logic    advance;

   assign advance        = in_valid_ff && (!out_valid_ff || rsp_chan.ready);
   assign req_chan.ready = !in_valid_ff || advance;
   assign csr_chan.ready = 1'b1;

   // Register writes
   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff <= '{led_phase_ticks: LED_PHASE_RST, heartbeat_ticks: HEARTBEAT_RST,
                     init_ticks: INIT_RST, blink_ticks: BLINK_RST, start_code: START_RST};
      end else if (csr_chan.valid) begin
         unique case (csr_chan.index)
            CSR_LED_PHASE: cfg_ff.led_phase_ticks <= csr_chan.data;
            CSR_HEARTBEAT: cfg_ff.heartbeat_ticks <= csr_chan.data;
            CSR_INIT:      cfg_ff.init_ticks      <= csr_chan.data;
            CSR_BLINK:     cfg_ff.blink_ticks     <= csr_chan.data;
            CSR_START:     cfg_ff.start_code      <= csr_chan.data;
            default: ;
         endcase
      end
   end

   // Input register: take a request whenever the slot is free or draining
   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else if (req_chan.ready) begin
         in_valid_ff <= req_chan.valid;
      end
   end

   always_ff @(posedge clock) begin
      if (req_chan.valid && req_chan.ready) begin
         in_data_ff <= '{left_low: req_chan.left_low, left_full: req_chan.left_full,
                         right_low: req_chan.right_low, right_full: req_chan.right_full,
                         host_command: req_chan.host_command};
      end
   end

   fdts_core #(
      .COUNT_WIDTH (COUNT_WIDTH)
   ) u_core (
      .clock (clock),
      .reset (reset),
      .step  (advance),
      .req   (in_data_ff),
      .cfg   (cfg_ff),
      .rsp   (core_rsp)
   );

   // Output register: load on advance, drop when taken
   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
      end else if (advance) begin
         out_valid_ff <= 1'b1;
      end else if (rsp_chan.ready) begin
         out_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         out_data_ff <= core_rsp;
      end
   end

   assign rsp_chan.valid            = out_valid_ff;
   assign rsp_chan.led_red          = out_data_ff.led_red;
   assign rsp_chan.led_green        = out_data_ff.led_green;
   assign rsp_chan.led_yellow       = out_data_ff.led_yellow;
   assign rsp_chan.left_light       = out_data_ff.left_light;
   assign rsp_chan.right_light      = out_data_ff.right_light;
   assign rsp_chan.valve_open       = out_data_ff.valve_open;
   assign rsp_chan.status_code      = out_data_ff.status_code;
   assign rsp_chan.left_empty_flag  = out_data_ff.left_empty_flag;
   assign rsp_chan.left_full_flag   = out_data_ff.left_full_flag;
   assign rsp_chan.right_empty_flag = out_data_ff.right_empty_flag;
   assign rsp_chan.right_full_flag  = out_data_ff.right_full_flag;
   assign rsp_chan.command_echo     = out_data_ff.command_echo;

   // A stalled result is never overwritten
   a_no_overwrite: assert property (@(posedge clock) disable iff (reset)
      out_valid_ff && !rsp_chan.ready |-> !advance)
      else $error("output register overwritten while stalled");

   // A full input stage with a free output always moves forward
   a_forward: assert property (@(posedge clock) disable iff (reset)
      in_valid_ff && !out_valid_ff |-> advance)
      else $error("pipeline bubble with free output");

   // Every advance yields a result in the next cycle
   a_result_follows: assert property (@(posedge clock) disable iff (reset)
      advance |=> out_valid_ff)
      else $error("advance without result");

endmodule
`default_nettype wire

// File: sim/tb_fill_drain_target_sequencer_top.sv
`default_nettype none
module tb_fill_drain_target_sequencer_top;
   import fdts_pkg::*;

   typedef enum logic [2:0] {
      MODE_INIT, MODE_WAIT, MODE_FILL, MODE_BOTH, MODE_DRAIN, MODE_DRAINED
   } mode_type;

   localparam logic [STAT_W-1:0] ST_POWER_ON  = 3'd0;
   localparam logic [STAT_W-1:0] ST_INIT      = 3'd1;
   localparam logic [STAT_W-1:0] ST_WAITING   = 3'd2;
   localparam logic [STAT_W-1:0] ST_FILLING   = 3'd3;
   localparam logic [STAT_W-1:0] ST_BOTH_FULL = 3'd4;
   localparam logic [STAT_W-1:0] ST_DRAINING  = 3'd5;
   localparam logic [STAT_W-1:0] ST_DRAINED   = 3'd6;

   localparam int unsigned COUNT_MAX = (1 << CNT_W_DEF) - 1;
   localparam int WATCHDOG_LIMIT = 2000;
   localparam int DIR_ROWS = 25;

   // One row of the directed table: the request, and a typed-in result where pinned
   typedef struct packed {
      req_type stim;
      logic    pinned;
      rsp_type want;
   } dir_row_type;

   localparam rsp_type NO_PIN         = '0;
   localparam rsp_type WANT_RED       = {1'b1, 5'b0, ST_POWER_ON, 4'b0, 16'h0000};
   localparam rsp_type WANT_RED_GREEN = {2'b11, 4'b0, ST_POWER_ON, 4'b0, 16'h0000};

   // Power-on walk with short phases, then initialization, a start attempt on wet
   // tanks, a wrong start word, a good start, one full then both full, drain, drained
   localparam dir_row_type DIR_TABLE [DIR_ROWS] = '{
      {1'b1, 1'b1, 1'b1, 1'b1, 16'hFFFF, 1'b1, WANT_RED},
      {1'b0, 1'b0, 1'b0, 1'b0, 16'h0000, 1'b0, NO_PIN},
      {1'b1, 1'b0, 1'b1, 1'b0, 16'hFFFF, 1'b0, NO_PIN},
      {1'b0, 1'b1, 1'b0, 1'b1, 16'h0000, 1'b1, WANT_RED_GREEN},
      {1'b1, 1'b1, 1'b1, 1'b1, 16'hAAAA, 1'b0, NO_PIN},
      {1'b0, 1'b0, 1'b0, 1'b0, 16'h5555, 1'b0, NO_PIN},
      {1'b1, 1'b1, 1'b0, 1'b0, 16'h00A5, 1'b0, NO_PIN},
      {1'b0, 1'b0, 1'b1, 1'b1, 16'h00A5, 1'b0, NO_PIN},
      {1'b1, 1'b0, 1'b0, 1'b1, 16'h8001, 1'b0, NO_PIN},
      {1'b0, 1'b1, 1'b1, 1'b0, 16'h7FFE, 1'b0, NO_PIN},
      {1'b0, 1'b0, 1'b0, 1'b0, 16'h0001, 1'b0, NO_PIN},
      {1'b1, 1'b1, 1'b1, 1'b1, 16'hFFFF, 1'b0, NO_PIN},
      {1'b0, 1'b0, 1'b0, 1'b0, 16'h00A5, 1'b0, NO_PIN},
      {1'b1, 1'b0, 1'b0, 1'b1, 16'h1234, 1'b0, NO_PIN},
      {1'b0, 1'b1, 1'b1, 1'b0, 16'h00A5, 1'b0, NO_PIN},
      {1'b0, 1'b0, 1'b0, 1'b0, 16'h0000, 1'b0, NO_PIN},
      {1'b1, 1'b0, 1'b0, 1'b0, 16'h00A5, 1'b0, NO_PIN},
      {1'b0, 1'b0, 1'b0, 1'b0, 16'h00A4, 1'b0, NO_PIN},
      {1'b0, 1'b0, 1'b0, 1'b0, 16'h00A5, 1'b0, NO_PIN},
      {1'b1, 1'b1, 1'b0, 1'b0, 16'hFFFF, 1'b0, NO_PIN},
      {1'b1, 1'b1, 1'b1, 1'b1, 16'h0000, 1'b0, NO_PIN},
      {1'b1, 1'b1, 1'b1, 1'b1, 16'hBEEF, 1'b0, NO_PIN},
      {1'b1, 1'b0, 1'b0, 1'b0, 16'h00A5, 1'b0, NO_PIN},
      {1'b0, 1'b0, 1'b0, 1'b0, 16'h00A5, 1'b0, NO_PIN},
      {1'b0, 1'b1, 1'b0, 1'b1, 16'hC3C3, 1'b0, NO_PIN}
   };

   logic clock;
   logic reset;

   fdts_req_if req_bus();
   fdts_rsp_if rsp_bus();
   fdts_csr_if csr_bus();

   fill_drain_target_sequencer_top DUT (
      .clock    (clock),
      .reset    (reset),
      .req_chan (req_bus),
      .rsp_chan (rsp_bus),
      .csr_chan (csr_bus)
   );

   // Shadow of the sequencer: registers, counters, mode and the panel it reports
   cfg_type     regs;
   logic [2:0]  pon_phase;
   int unsigned pon_count;
   int unsigned blink_count;
   int unsigned init_count;
   logic        first_beat;
   mode_type    mode;
   rsp_type     panel;

   rsp_type due_panels[$];
   logic    pin_on;
   rsp_type pin_panel;
   int      send_idle_pct;
   int      rcv_idle_pct;
   int      sent;
   int      errors;
   int      stall_cycles;

   initial begin
      clock = 1'b0;
      forever #1 clock = ~clock;
   end

   // Zero acts as one; anything past the counter range is clamped
   function automatic int unsigned period_of(logic [REG_W-1:0] v);
      if (v == '0) return 1;
      return (int'(v) > COUNT_MAX) ? COUNT_MAX : int'(v);
   endfunction

   function automatic int unsigned bump(int unsigned c);
      return (c >= COUNT_MAX) ? COUNT_MAX : c + 1;
   endfunction

   function automatic void lights_valve_off();
      panel.left_light  = 1'b0;
      panel.right_light = 1'b0;
      panel.valve_open  = 1'b0;
   endfunction

   // Advance the shadow by one tick and return the panel it reports
   function automatic rsp_type predict_tick(req_type r);
      logic        all_dry;
      int unsigned per;
      all_dry = !(r.left_low | r.left_full | r.right_low | r.right_full);

      // power-on lamp walk, then the green heartbeat with flag reload
      if (pon_phase != 0) begin
         if (pon_count < int'(regs.led_phase_ticks)) begin
            pon_count = bump(pon_count);
            case (pon_phase)
               3'd4: panel.led_red = 1'b1;
               3'd3: panel.led_green = 1'b1;
               3'd2: panel.led_yellow = 1'b1;
               default: begin
                  panel.led_yellow = 1'b0;
                  panel.led_red    = 1'b0;
               end
            endcase
         end else begin
            pon_count = 0;
            pon_phase = pon_phase - 3'd1;
         end
      end else begin
         per = period_of(first_beat ? regs.led_phase_ticks : regs.heartbeat_ticks);
         pon_count = bump(pon_count);
         if (pon_count >= per) begin
            panel.led_green        = ~panel.led_green;
            pon_count              = 0;
            first_beat             = 1'b0;
            panel.left_empty_flag  = r.left_low;
            panel.left_full_flag   = r.left_full;
            panel.right_empty_flag = r.right_low;
            panel.right_full_flag  = r.right_full;
         end
      end

      // mode machine runs once the lamp walk is over
      if (pon_phase == 0) begin
         case (mode)
            MODE_INIT: begin
               panel.left_light  = 1'b1;
               panel.right_light = 1'b1;
               panel.valve_open  = 1'b1;
               init_count = bump(init_count);
               if (init_count >= period_of(regs.init_ticks)) begin
                  lights_valve_off();
                  panel.status_code = ST_INIT;
                  mode = MODE_WAIT;
               end
            end
            MODE_WAIT: begin
               panel.status_code = ST_WAITING;
               blink_count = bump(blink_count);
               if (blink_count >= period_of(regs.blink_ticks)) begin
                  panel.left_light  = ~panel.left_light;
                  panel.right_light = ~panel.right_light;
                  blink_count = 0;
               end
               panel.command_echo = r.host_command;
               if (r.host_command == regs.start_code && all_dry) begin
                  lights_valve_off();
                  mode = MODE_FILL;
               end
            end
            MODE_FILL: begin
               panel.status_code = ST_FILLING;
               if (r.left_full) begin
                  panel.left_light     = 1'b1;
                  panel.left_full_flag = 1'b1;
               end
               if (r.right_full) begin
                  panel.right_light     = 1'b1;
                  panel.right_full_flag = 1'b1;
               end
               if (r.left_full && r.right_full) mode = MODE_BOTH;
            end
            MODE_BOTH: begin
               panel.valve_open  = 1'b1;
               panel.status_code = ST_BOTH_FULL;
               mode = MODE_DRAIN;
            end
            MODE_DRAIN: begin
               panel.status_code = ST_DRAINING;
               if (all_dry) begin
                  panel.left_full_flag  = 1'b0;
                  panel.right_full_flag = 1'b0;
                  mode = MODE_DRAINED;
               end
            end
            default: begin
               lights_valve_off();
               panel.left_empty_flag  = 1'b1;
               panel.right_empty_flag = 1'b1;
               panel.status_code = ST_DRAINED;
               mode = MODE_WAIT;
            end
         endcase
      end
      return panel;
   endfunction

   task automatic check_field(input string name, input int unsigned exp, input int unsigned act);
      if (exp != act) begin
         $error("%s: expected 0x%0h, got 0x%0h", name, exp, act);
         errors++;
      end
   endtask

   task automatic compare_panel(input rsp_type exp, input rsp_type act);
      check_field("led_red", exp.led_red, act.led_red);
      check_field("led_green", exp.led_green, act.led_green);
      check_field("led_yellow", exp.led_yellow, act.led_yellow);
      check_field("left_light", exp.left_light, act.left_light);
      check_field("right_light", exp.right_light, act.right_light);
      check_field("valve_open", exp.valve_open, act.valve_open);
      check_field("status_code", exp.status_code, act.status_code);
      check_field("left_empty_flag", exp.left_empty_flag, act.left_empty_flag);
      check_field("left_full_flag", exp.left_full_flag, act.left_full_flag);
      check_field("right_empty_flag", exp.right_empty_flag, act.right_empty_flag);
      check_field("right_full_flag", exp.right_full_flag, act.right_full_flag);
      check_field("command_echo", exp.command_echo, act.command_echo);
   endtask

   // Stall the result side at random
   always @(posedge clock) begin
      rsp_bus.ready <= ($urandom_range(99) >= rcv_idle_pct);
   end

   // Predict on each accepted request, check each accepted result, watch for hangs
   always @(posedge clock) begin
      rsp_type want;
      rsp_type got;
      if (!reset) begin
         if (req_bus.valid && req_bus.ready) begin
            want = predict_tick({req_bus.left_low, req_bus.left_full, req_bus.right_low,
                                 req_bus.right_full, req_bus.host_command});
            if (pin_on) want = pin_panel;
            due_panels.push_back(want);
         end
         if (rsp_bus.valid && rsp_bus.ready) begin
            got = {rsp_bus.led_red, rsp_bus.led_green, rsp_bus.led_yellow,
                   rsp_bus.left_light, rsp_bus.right_light, rsp_bus.valve_open,
                   rsp_bus.status_code, rsp_bus.left_empty_flag, rsp_bus.left_full_flag,
                   rsp_bus.right_empty_flag, rsp_bus.right_full_flag, rsp_bus.command_echo};
            if (due_panels.size() == 0) begin
               $error("result with no request pending: %h", got);
               errors++;
            end else begin
               compare_panel(due_panels.pop_front(), got);
            end
         end
         if ((req_bus.valid && req_bus.ready) || (rsp_bus.valid && rsp_bus.ready) ||
             (csr_bus.valid && csr_bus.ready))
            stall_cycles = 0;
         else
            stall_cycles++;
         if (stall_cycles >= WATCHDOG_LIMIT) begin
            $display("** fill_drain_target_sequencer_top: FAILED **");
            $finish;
         end
      end
   end

   // Write one register and mirror it into the shadow
   task automatic write_reg(input logic [CSR_IDX_W-1:0] idx, input logic [REG_W-1:0] value);
      csr_bus.valid <= 1'b1;
      csr_bus.index <= idx;
      csr_bus.data  <= value;
      do @(posedge clock); while (!csr_bus.ready);
      case (idx)
         CSR_LED_PHASE: regs.led_phase_ticks = value;
         CSR_HEARTBEAT: regs.heartbeat_ticks = value;
         CSR_INIT:      regs.init_ticks = value;
         CSR_BLINK:     regs.blink_ticks = value;
         CSR_START:     regs.start_code = value;
         default: ;
      endcase
   endtask

   task automatic load_registers(input cfg_type c);
      write_reg(CSR_LED_PHASE, c.led_phase_ticks);
      write_reg(CSR_HEARTBEAT, c.heartbeat_ticks);
      write_reg(CSR_INIT, c.init_ticks);
      write_reg(CSR_BLINK, c.blink_ticks);
      write_reg(CSR_START, c.start_code);
      csr_bus.valid <= 1'b0;
   endtask

   // Offer one request after a random gap and hold it until accepted
   task automatic send_tick(input req_type r, input logic pinned = 1'b0,
                            input rsp_type want = '0);
      while ($urandom_range(99) < send_idle_pct) begin
         req_bus.valid <= 1'b0;
         @(posedge clock);
      end
      req_bus.valid        <= 1'b1;
      req_bus.left_low     <= r.left_low;
      req_bus.left_full    <= r.left_full;
      req_bus.right_low    <= r.right_low;
      req_bus.right_full   <= r.right_full;
      req_bus.host_command <= r.host_command;
      pin_on               <= pinned;
      pin_panel            <= want;
      do @(posedge clock); while (!req_bus.ready);
      sent++;
   endtask

   // Hold off requests until every predicted result has come back
   task automatic pause_until_drained();
      req_bus.valid <= 1'b0;
      @(posedge clock);
      while (due_panels.size() != 0) @(posedge clock);
   endtask

   function automatic req_type random_req();
      req_type r;
      r.left_low     = 1'($urandom_range(1));
      r.left_full    = 1'($urandom_range(1));
      r.right_low    = 1'($urandom_range(1));
      r.right_full   = 1'($urandom_range(1));
      r.host_command = 16'($urandom_range(16'hFFFF));
      return r;
   endfunction

   function automatic req_type dry_req();
      req_type r;
      r = random_req();
      r.left_low   = 1'b0;
      r.left_full  = 1'b0;
      r.right_low  = 1'b0;
      r.right_full = 1'b0;
      return r;
   endfunction

   // One well-formed pass: wait, start, fill to both full, drain, drained
   task automatic fill_drain_run();
      req_type r;
      repeat ($urandom_range(0, 3)) send_tick(random_req());
      r = dry_req();
      r.host_command = regs.start_code;
      repeat ($urandom_range(1, 2)) send_tick(r);
      repeat ($urandom_range(1, 5)) send_tick(random_req());
      r = random_req();
      r.left_full  = 1'b1;
      r.right_full = 1'b1;
      send_tick(r);
      repeat ($urandom_range(1, 5)) send_tick(random_req());
      send_tick(dry_req());
      send_tick(random_req());
   endtask

   // Mostly complete passes, some loose requests that carry the start word at random
   task automatic random_traffic(input int count);
      int      stop_at;
      req_type r;
      stop_at = sent + count;
      while (sent < stop_at) begin
         if ($urandom_range(4) == 0) begin
            repeat ($urandom_range(1, 8)) begin
               r = random_req();
               if ($urandom_range(2) == 0) r.host_command = regs.start_code;
               send_tick(r);
            end
         end else begin
            fill_drain_run();
         end
      end
   endtask

   initial begin
      req_bus.valid        <= 1'b0;
      req_bus.left_low     <= 1'b0;
      req_bus.left_full    <= 1'b0;
      req_bus.right_low    <= 1'b0;
      req_bus.right_full   <= 1'b0;
      req_bus.host_command <= '0;
      csr_bus.valid        <= 1'b0;
      csr_bus.index        <= '0;
      csr_bus.data         <= '0;
      pin_on               <= 1'b0;
      pin_panel            <= '0;
      send_idle_pct = 0;
      rcv_idle_pct  = 0;
      sent          = 0;
      errors        = 0;
      stall_cycles  = 0;

      // shadow starts where reset leaves the block
      regs = '{LED_PHASE_RST, HEARTBEAT_RST, INIT_RST, BLINK_RST, START_RST};
      pon_phase   = 3'd4;
      pon_count   = 0;
      blink_count = 0;
      init_count  = 0;
      first_beat  = 1'b1;
      mode        = MODE_INIT;
      panel       = '0;
      panel.led_red = 1'b1;

      reset = 1'b1;
      repeat (7) @(posedge clock);
      reset <= 1'b0;

      // short periods so the lamp walk and initialization finish early
      send_idle_pct = 30;
      rcv_idle_pct  = 81;
      load_registers('{16'd2, 16'd3, 16'd5, 16'd2, 16'h00A5});
      for (int i = 0; i < DIR_ROWS; i++)
         send_tick(DIR_TABLE[i].stim, DIR_TABLE[i].pinned, DIR_TABLE[i].want);
      random_traffic(95);
      pause_until_drained();

      // largest unused periods, fastest blink and heartbeat, start word zero
      send_idle_pct = 81;
      rcv_idle_pct  = 30;
      load_registers('{16'hFFFF, 16'd1, 16'hFFFF, 16'd1, 16'h0000});
      random_traffic(45);
      pause_until_drained();
      random_traffic(50);
      pause_until_drained();

      // zero periods act as one, start word all ones
      send_idle_pct = 0;
      rcv_idle_pct  = 0;
      load_registers('{16'd1, 16'd0, 16'd1, 16'd0, 16'hFFFF});
      random_traffic(95);
      pause_until_drained();

      // longest heartbeat and blink, cut short from running counts
      load_registers('{16'd0, 16'hFFFF, 16'd0, 16'hFFFF, 16'h5A3C});
      random_traffic(95);
      pause_until_drained();

      repeat (8) @(posedge clock);
      if (errors == 0)
         $display("** fill_drain_target_sequencer_top: PASSED **");
      else
         $display("** fill_drain_target_sequencer_top: FAILED **");
      $finish;
   end

endmodule
`default_nettype wire
